>>> rtl/core/stmin_pkg.sv
// Shared constants, types and helper functions for the sparse-table range-minimum block.
package stmin_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int LEVELS       = 11;

    localparam int DATA_W = 32;
    localparam int POS_W  = $clog2(MAX_ELEMENTS);
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int SPAN_W = CNT_W + 1;
    localparam int LVL_W  = $clog2(LEVELS + 1);
    localparam int ADDR_W = $clog2(LEVELS * MAX_ELEMENTS);

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_APPEND = 2'd0;
    localparam t_kind KIND_QUERY  = 2'd1;
    localparam t_kind KIND_CLEAR  = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_BAD_RANGE = 2'd1;
    localparam t_status ST_FULL      = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic app_step;
        logic q_issue_a;
        logic q_issue_b;
        logic q_min;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_kind kind;
        logic  full;
        logic  bad;
        logic  app_more;
        logic  out_free;
    } t_sts;

    function automatic logic signed [DATA_W-1:0] smin(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        smin = (a < b) ? a : b;
    endfunction

    // floor(log2(x)) for x >= 1, clamped to the top level
    function automatic logic [LVL_W-1:0] floor_log2(input logic [CNT_W-1:0] x);
        logic [LVL_W-1:0] r;
        r = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (x[i]) begin
                r = LVL_W'(i);
            end
        end
        if (r > LVL_W'(LEVELS - 1)) begin
            r = LVL_W'(LEVELS - 1);
        end
        floor_log2 = r;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [LVL_W-1:0] lvl,
        input logic [POS_W-1:0] pos
    );
        cell_addr = ADDR_W'(ADDR_W'(lvl) * ADDR_W'(MAX_ELEMENTS)) + ADDR_W'(pos);
    endfunction

endpackage

>>> rtl/core/stmin_dp.sv
// Datapath: level table memory, element count, append/query arithmetic and result register.
module stmin_dp import stmin_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    input  t_kind                    i_kind,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [POS_W-1:0]         i_left,
    input  logic [POS_W-1:0]         i_right,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_min_value,
    output t_status                  o_status,
    output logic [CNT_W-1:0]         o_element_count
);

    logic signed [DATA_W-1:0] r_mem [LEVELS*MAX_ELEMENTS];
    logic signed [DATA_W-1:0] r_rdata;

    t_kind                    r_kind;
    logic signed [DATA_W-1:0] r_value;
    logic [POS_W-1:0]         r_left;
    logic [POS_W-1:0]         r_right;
    logic signed [DATA_W-1:0] r_run;
    logic [LVL_W-1:0]         r_level;
    logic [LVL_W-1:0]         r_qlvl;
    logic [CNT_W-1:0]         r_count;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_min;
    t_status                  r_out_status;
    logic [CNT_W-1:0]         r_out_count;

    logic                     full;
    logic                     bad;
    logic [SPAN_W-1:0]        p1;
    logic [LVL_W-1:0]         lvl_nxt;
    logic [SPAN_W-1:0]        span_cur;
    logic [SPAN_W-1:0]        span_nxt;
    logic [POS_W-1:0]         s_cur;
    logic [POS_W-1:0]         s_nxt;
    logic                     app_more;
    logic signed [DATA_W-1:0] wdata;
    logic [CNT_W-1:0]         q_len;
    logic [LVL_W-1:0]         q_lvl;
    logic [SPAN_W-1:0]        q_span;
    logic [POS_W-1:0]         q_b_pos;
    logic [ADDR_W-1:0]        rd_addr;
    logic [CNT_W-1:0]         n_count;
    t_status                  res_status;
    logic signed [DATA_W-1:0] res_min;

    assign full = (r_count >= CNT_W'(MAX_ELEMENTS));
    assign bad  = (r_left > r_right) || (CNT_W'(r_right) >= r_count);

    // append: position p = count, window at level j starts at p+1-2^j
    assign p1       = SPAN_W'(r_count) + SPAN_W'(1);
    assign lvl_nxt  = r_level + LVL_W'(1);
    assign span_cur = SPAN_W'(1) << r_level;
    assign span_nxt = SPAN_W'(1) << lvl_nxt;
    assign s_cur    = POS_W'(p1 - span_cur);
    assign s_nxt    = POS_W'(p1 - span_nxt);
    assign app_more = (lvl_nxt < LVL_W'(LEVELS)) && (span_nxt <= p1);
    // level j-1 window ending at p is the running minimum, the other half comes from memory
    assign wdata    = (r_level == '0) ? r_value : smin(r_rdata, r_run);

    // query: two windows of length 2^floor(log2(len))
    assign q_len   = CNT_W'(r_right) - CNT_W'(r_left) + CNT_W'(1);
    assign q_lvl   = floor_log2(q_len);
    assign q_span  = SPAN_W'(1) << r_qlvl;
    assign q_b_pos = POS_W'(SPAN_W'(r_right) + SPAN_W'(1) - q_span);

    always_comb begin
        rd_addr = '0;
        if (i_cmd.app_step) begin
            rd_addr = cell_addr(r_level, s_nxt);
        end else if (i_cmd.q_issue_a) begin
            rd_addr = cell_addr(q_lvl, r_left);
        end else if (i_cmd.q_issue_b) begin
            rd_addr = cell_addr(r_qlvl, q_b_pos);
        end
    end

    always_comb begin
        n_count    = r_count;
        res_status = ST_OK;
        res_min    = '0;
        case (r_kind)
            KIND_APPEND: begin
                if (full) begin
                    res_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            KIND_QUERY: begin
                if (bad) begin
                    res_status = ST_BAD_RANGE;
                end else begin
                    res_min = r_run;
                end
            end
            KIND_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.app_step) begin
            r_mem[cell_addr(r_level, s_cur)] <= wdata;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_value <= i_value;
            r_left  <= i_left;
            r_right <= i_right;
            r_level <= '0;
        end
        if (i_cmd.app_step) begin
            r_run   <= wdata;
            r_level <= lvl_nxt;
        end
        if (i_cmd.q_issue_a) begin
            r_qlvl <= q_lvl;
        end
        if (i_cmd.q_issue_b) begin
            r_run <= r_rdata;
        end
        if (i_cmd.q_min) begin
            r_run <= smin(r_run, r_rdata);
        end
        if (i_cmd.finish) begin
            r_out_min    <= res_min;
            r_out_status <= res_status;
            r_out_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.kind     = r_kind;
    assign o_sts.full     = full;
    assign o_sts.bad      = bad;
    assign o_sts.app_more = app_more;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_min_value     = r_out_min;
    assign o_status        = r_out_status;
    assign o_element_count = r_out_count;

    a_step_only_on_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.app_step |-> (r_kind == KIND_APPEND) && !full)
        else $error("append step with full table");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_count <= CNT_W'(MAX_ELEMENTS)))
        else $error("element count beyond table size");

endmodule

>>> rtl/core/stmin_ctrl.sv
// Controller: sequences append level fills, query reads and result hand-off.
module stmin_ctrl import stmin_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_APP,
        S_QRD2,
        S_QMIN,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_stall;
    logic   accept;

    assign accept = i_in_valid && !r_in_stall;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = accept;
                if (accept) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.kind == KIND_APPEND && !i_sts.full) begin
                    n_state = S_APP;
                end else if (i_sts.kind == KIND_QUERY && !i_sts.bad) begin
                    o_cmd.q_issue_a = 1'b1;
                    n_state         = S_QRD2;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_APP: begin
                o_cmd.app_step = 1'b1;
                if (!i_sts.app_more) begin
                    n_state = S_FIN;
                end
            end
            S_QRD2: begin
                o_cmd.q_issue_b = 1'b1;
                n_state         = S_QMIN;
            end
            S_QMIN: begin
                o_cmd.q_min = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_in_stall <= 1'b1;
            end else if (o_cmd.finish) begin
                r_in_stall <= 1'b0;
            end
        end
    end

    assign o_in_stall = r_in_stall;

    a_finish_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_sts.out_free)
        else $error("result written over a waiting result");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_in_stall && (r_state == S_DECODE))
        else $error("request accepted but controller not busy");

    a_stall_tracks_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) == !r_in_stall)
        else $error("stall out of step with controller state");

endmodule

>>> rtl/core/sparse_table_range_min.sv
// Top level of the sparse-table range-minimum block.
//
// Input channel (i_in_valid / o_in_stall) carries one request: kind, value, left, right.
//   kind append stores value as the next element and fills, level by level, the
//   power-of-two windows that end at it; kind query returns min(left..right);
//   kind clear empties the table. Every request yields exactly one result.
// Output channel (o_out_valid / i_out_stall) carries min_value, status, element_count.
// From acceptance to o_out_valid, an append goes through the decode step, one fill step for
// each of the L levels filled (1 to 11, limited by the element position) and the hand-off
// step; a good query goes through decode with the first table read, the second read, a
// minimum step and hand-off; clear, bad query, full append and unused kind go from decode
// straight to hand-off. The next request is taken the cycle after the result is written.
// The work is set by the level table with one write port and one read port: one table write
// per level on append and two reads on a query, plus the decode and hand-off steps of the controller.
// A result waits in the output register while i_out_stall is high; the block still
// takes and works on one new request meanwhile, and holds that one until the register frees.
// Reset (i_rst_n low, synchronous) sets the element count to zero and drops o_out_valid.
// Table contents are not cleared; only entries already filled by appends ever feed a result.
module sparse_table_range_min import stmin_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_kind,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [POS_W-1:0]         i_left,
    input  logic [POS_W-1:0]         i_right,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_min_value,
    output logic [1:0]               o_status,
    output logic [CNT_W-1:0]         o_element_count
);

    t_cmd cmd;
    t_sts sts;

    stmin_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    stmin_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_kind          (i_kind),
        .i_value         (i_value),
        .i_left          (i_left),
        .i_right         (i_right),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_min_value     (o_min_value),
        .o_status        (o_status),
        .o_element_count (o_element_count)
    );

endmodule
